### hw/rtl/cfr_pkg.sv
package cfr_pkg;

    localparam int unsigned CFR_MAX_PAYLOAD = 1028;

    localparam int unsigned CFG_W   = 11;
    localparam int unsigned IDX_W   = 11;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned TDATA_W = 40;

    localparam logic [7:0]  SYNC_BYTE = 8'h4A;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_END_OK   = 2'd1,
        KIND_END_BAD  = 2'd2,
        KIND_LEN_BAD  = 2'd3
    } t_kind;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [7:0]       command;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] payload_index;
        logic [IDX_W-1:0] frame_length;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

### hw/rtl/crc16_frame_receiver.sv
// Length-prefixed frame receiver with CRC-16/MODBUS check.
// Slave stream (s_axis_*): one received byte per transaction. Bytes are dropped
// until the sync byte 0x4A; then come command, 16-bit little-endian length,
// payload and a little-endian CRC over everything before it.
// Master stream (m_axis_*): zero or one result per input byte. tuser carries
// the kind (payload byte, frame ok, CRC mismatch, length too large); tdata
// carries command, data byte, payload index and announced length.
// Configuration channel (i_cfg_*): writes the largest accepted payload length;
// write it only while no byte is in flight.
// Throughput: one byte per cycle while no result waits on m_axis_tready, set by the
// CRC and parse step between the input register and the result register.
// Path: a byte is held in the input register, then its result in the result register.
// Reset: parser hunts for sync, CRC accumulator at 0xFFFF, limit at 1028.
// Stall: while a result waits on m_axis_tready, the byte in the input register
// holds; s_axis_tready drops only when both stages are full.
module crc16_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = cfr_pkg::CFR_MAX_PAYLOAD
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // rx_byte[7:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // command[7:0], data_byte[15:8], payload_index[26:16], frame_length[37:27], zero[39:38]
    output logic [cfr_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                  m_axis_tuser,   // kind[1:0]
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cfr_pkg::CFG_W-1:0]   i_cfg_data
);
    import cfr_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_out;
    logic [CFG_W-1:0] r_max_payload;
    logic             advance;
    logic             step;
    t_result          core_result;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    cfr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= CFG_W'(CFR_MAX_PAYLOAD);
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && core_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {2'b00, r_out.frame_length, r_out.payload_index,
                            r_out.data_byte, r_out.command};

endmodule

### hw/rtl/cfr_core.sv
module cfr_core #(
    parameter int unsigned MAX_PAYLOAD = cfr_pkg::CFR_MAX_PAYLOAD
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic [cfr_pkg::CFG_W-1:0] i_max_payload,
    output cfr_pkg::t_result       o_result
);
    import cfr_pkg::*;

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PAYLOAD);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_cmd, n_cmd;
    logic [IDX_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_lo, n_crc_lo;

    logic [LEN_W-1:0] len_full;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] limit;
    logic             len_bad;
    logic [IDX_W-1:0] count_inc;
    logic [15:0]      crc_upd;
    logic [15:0]      crc_got;

    assign len_full  = {i_byte, r_len[7:0]};
    assign len_sat   = (len_full < MaxLen) ? len_full : MaxLen;
    assign limit     = ({{(LEN_W-CFG_W){1'b0}}, i_max_payload} < MaxLen)
                     ? {{(LEN_W-CFG_W){1'b0}}, i_max_payload} : MaxLen;
    assign len_bad   = len_full > limit;
    assign count_inc = r_count + IDX_W'(1);
    assign crc_upd   = crc16_byte((r_phase == PH_HUNT) ? CRC_INIT : r_crc, i_byte);
    assign crc_got   = {i_byte, r_crc_lo};

    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                PH_HUNT:    n_phase = (i_byte == SYNC_BYTE) ? PH_CMD : PH_HUNT;
                PH_CMD:     n_phase = PH_LEN_LO;
                PH_LEN_LO:  n_phase = PH_LEN_HI;
                PH_LEN_HI: begin
                    if (len_bad) begin
                        n_phase = PH_HUNT;
                    end else if (len_full[IDX_W-1:0] == '0) begin
                        n_phase = PH_CRC_LO;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: n_phase = (count_inc >= r_len) ? PH_CRC_LO : PH_PAYLOAD;
                PH_CRC_LO:  n_phase = PH_CRC_HI;
                PH_CRC_HI:  n_phase = PH_HUNT;
                default:    n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        o_result = '{valid: 1'b0, kind: KIND_PAYLOAD, command: r_cmd, data_byte: 8'h00,
                     payload_index: '0, frame_length: r_len};
        if (i_step) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == SYNC_BYTE) begin
                        n_crc = crc_upd;
                    end
                end
                PH_CMD: begin
                    n_cmd = i_byte;
                    n_crc = crc_upd;
                end
                PH_LEN_LO: begin
                    n_len = {{(IDX_W-8){1'b0}}, i_byte};
                    n_crc = crc_upd;
                end
                PH_LEN_HI: begin
                    n_crc = crc_upd;
                    if (len_bad) begin
                        n_len = len_sat[IDX_W-1:0];
                        o_result.valid        = 1'b1;
                        o_result.kind         = KIND_LEN_BAD;
                        o_result.frame_length = len_sat[IDX_W-1:0];
                    end else begin
                        n_len   = len_full[IDX_W-1:0];
                        n_count = '0;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc   = crc_upd;
                    n_count = count_inc;
                    o_result.valid         = 1'b1;
                    o_result.kind          = KIND_PAYLOAD;
                    o_result.data_byte     = i_byte;
                    o_result.payload_index = r_count;
                end
                PH_CRC_LO: begin
                    n_crc_lo = i_byte;
                end
                PH_CRC_HI: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = (crc_got == r_crc) ? KIND_END_OK : KIND_END_BAD;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_cmd    <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule
